// File: rtl/core/sttok_pkg.sv
// shared types, codes and byte classes for the schema text tokenizer
// used by every module under rtl/core; depends on nothing else
package sttok_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    KindSymbol = 3'd0,
    KindIdent  = 3'd1,
    KindNumber = 3'd2,
    KindOther  = 3'd3,
    KindEnd    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ModeIdle   = 3'd0,
    ModeIdent  = 3'd1,
    ModeSign   = 3'd2,
    ModeZero   = 3'd3,
    ModeDec    = 3'd4,
    ModeHex    = 3'd5,
    ModeSingle = 3'd6
  } mode_e;

  typedef enum logic {
    OpChar  = 1'b0,
    OpFlush = 1'b1
  } op_e;

  // one queue entry: the results caused by one request, at most a token byte and an end token
  typedef struct packed {
    logic       has_tok;
    logic [7:0] tok_byte;
    kind_e      tok_kind;
    logic       tok_first;
    logic       tok_last;
    logic       has_end;
  } entry_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0d]});
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || (c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]});
  endfunction

  function automatic logic is_sym(logic [7:0] c);
    return c inside {8'h7b, 8'h7d, 8'h28, 8'h29, 8'h2f, 8'h2a, 8'h3b,
                     8'h2c, 8'h3c, 8'h3e, 8'h2e, 8'h7c, 8'h40};
  endfunction

  // mode after c when it continues the current token, idle when it does not
  function automatic mode_e extend_mode(mode_e mode, logic [7:0] c);
    mode_e res;
    res = ModeIdle;
    case (mode)
      ModeIdent: begin
        if (is_alpha(c) || is_digit(c) || c == 8'h5f || c == 8'h3a) res = ModeIdent;
      end
      ModeSign: begin
        if (c == 8'h30) res = ModeZero;
        else if (is_digit(c)) res = ModeDec;
      end
      ModeZero: begin
        if (c == 8'h78 || c == 8'h58) res = ModeHex;
        else if (is_digit(c)) res = ModeDec;
      end
      ModeDec: begin
        if (is_digit(c)) res = ModeDec;
      end
      ModeHex: begin
        if (is_hex(c)) res = ModeHex;
      end
      default: res = ModeIdle;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/sttok_front.sv
// front end: accepts requests, classes each byte and tracks the held byte
// depends on sttok_pkg; pushes result entries into sttok_queue
module sttok_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          char_byte_i,
  input  logic                q_full_i,
  output logic                push_o,
  output sttok_pkg::entry_t   entry_o
);

  logic                  held_valid_q, held_valid_d;
  logic [7:0]            held_byte_q, held_byte_d;
  sttok_pkg::kind_e      held_kind_q, held_kind_d;
  logic                  held_first_q, held_first_d;
  sttok_pkg::mode_e      mode_q, mode_d;
  sttok_pkg::mode_e      next_mode;
  logic                  accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign next_mode  = held_valid_q ? sttok_pkg::extend_mode(mode_q, char_byte_i)
                                   : sttok_pkg::ModeIdle;

  always_comb begin
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    held_kind_d  = held_kind_q;
    held_first_d = held_first_q;
    mode_d       = mode_q;

    entry_o.has_tok   = held_valid_q;
    entry_o.tok_byte  = held_byte_q;
    entry_o.tok_kind  = held_kind_q;
    entry_o.tok_first = held_first_q;
    entry_o.tok_last  = 1'b1;
    entry_o.has_end   = 1'b0;

    if (op_i == sttok_pkg::OpFlush) begin
      entry_o.has_end = 1'b1;
      held_valid_d = 1'b0;
      held_byte_d  = 8'h00;
      held_kind_d  = sttok_pkg::KindSymbol;
      held_first_d = 1'b0;
      mode_d       = sttok_pkg::ModeIdle;
    end else if (next_mode != sttok_pkg::ModeIdle) begin
      // byte continues the held token
      entry_o.tok_last = 1'b0;
      held_byte_d  = char_byte_i;
      held_first_d = 1'b0;
      mode_d       = next_mode;
    end else if (sttok_pkg::is_space(char_byte_i)) begin
      held_valid_d = 1'b0;
      held_byte_d  = 8'h00;
      held_kind_d  = sttok_pkg::KindSymbol;
      held_first_d = 1'b0;
      mode_d       = sttok_pkg::ModeIdle;
    end else begin
      held_valid_d = 1'b1;
      held_byte_d  = char_byte_i;
      held_first_d = 1'b1;
      if (sttok_pkg::is_sym(char_byte_i)) begin
        held_kind_d = sttok_pkg::KindSymbol;
        mode_d      = sttok_pkg::ModeSingle;
      end else if (sttok_pkg::is_alpha(char_byte_i) || char_byte_i == 8'h5f) begin
        held_kind_d = sttok_pkg::KindIdent;
        mode_d      = sttok_pkg::ModeIdent;
      end else if (char_byte_i == 8'h2b || char_byte_i == 8'h2d) begin
        held_kind_d = sttok_pkg::KindNumber;
        mode_d      = sttok_pkg::ModeSign;
      end else if (char_byte_i == 8'h30) begin
        held_kind_d = sttok_pkg::KindNumber;
        mode_d      = sttok_pkg::ModeZero;
      end else if (sttok_pkg::is_digit(char_byte_i)) begin
        held_kind_d = sttok_pkg::KindNumber;
        mode_d      = sttok_pkg::ModeDec;
      end else begin
        held_kind_d = sttok_pkg::KindOther;
        mode_d      = sttok_pkg::ModeSingle;
      end
    end
  end

  assign push_o = accept && (entry_o.has_tok || entry_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_byte_q  <= 8'h00;
      held_kind_q  <= sttok_pkg::KindSymbol;
      held_first_q <= 1'b0;
      mode_q       <= sttok_pkg::ModeIdle;
    end else if (accept) begin
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      held_kind_q  <= held_kind_d;
      held_first_q <= held_first_d;
      mode_q       <= mode_d;
    end
  end

endmodule

// File: rtl/core/sttok_queue.sv
// small queue of result entries between the front and back ends
// depends on sttok_pkg for the entry type
module sttok_queue #(
  parameter int unsigned Depth = sttok_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sttok_pkg::entry_t entry_i,
  output logic              full_o,
  output logic              head_valid_o,
  output sttok_pkg::entry_t head_o,
  input  logic              pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sttok_pkg::entry_t     slots_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    else if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= entry_i;
  end

endmodule

// File: rtl/core/sttok_back.sv
// back end: splits queue entries into single results and drives the output register
// depends on sttok_pkg; pops entries from sttok_queue
module sttok_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  sttok_pkg::entry_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [2:0]        kind_o,
  output logic              token_first_o,
  output logic              token_last_o,
  output logic              last_o
);

  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  sttok_pkg::kind_e kind_q, kind_d;
  logic             first_q, first_d;
  logic             tlast_q, tlast_d;
  logic             last_q, last_d;
  // set once the token byte of a two-result entry is loaded into the output register
  logic             phase_q, phase_d;
  logic             load;
  logic             send_tok;

  assign load     = !out_valid_q || out_ready_i;
  assign send_tok = head_i.has_tok && !phase_q;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    kind_d      = kind_q;
    first_d     = first_q;
    tlast_d     = tlast_q;
    last_d      = last_q;
    phase_d     = phase_q;
    pop_o       = 1'b0;
    if (load && head_valid_i) begin
      out_valid_d = 1'b1;
      if (send_tok) begin
        byte_d  = head_i.tok_byte;
        kind_d  = head_i.tok_kind;
        first_d = head_i.tok_first;
        tlast_d = head_i.tok_last;
        last_d  = !head_i.has_end;
        phase_d = head_i.has_end;
        pop_o   = !head_i.has_end;
      end else begin
        byte_d  = 8'h00;
        kind_d  = sttok_pkg::KindEnd;
        first_d = 1'b1;
        tlast_d = 1'b1;
        last_d  = 1'b1;
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    kind_q  <= kind_d;
    first_q <= first_d;
    tlast_q <= tlast_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign kind_o        = kind_q;
  assign token_first_o = first_q;
  assign token_last_o  = tlast_q;
  assign last_o        = last_q;

endmodule

// File: rtl/core/schema_text_tokenizer.sv
// top level of the schema text tokenizer: front end, result queue, back end
// depends on sttok_pkg, sttok_front, sttok_queue and sttok_back
//
// input channel (in_valid_i/in_ready_o): one request per byte, op_i = 0 carries
// char_byte_i, op_i = 1 marks end of input. one request is taken per cycle while in_ready_o is high.
// output channel (out_valid_o/out_ready_i): one token byte or end token per
// transfer, with kind, token_first, token_last and last flags.
// a source byte is held back until the next request shows whether it ends
// its token, so its result leaves with that next request.
// results of a request pass through the result queue into the output register.
// a byte request gives zero or one result, an end request one or two results,
// the token byte before the end token.
// throughput: one request per cycle while the output is taken every cycle;
// an end request with a held byte gives two output transfers.
// when the receiver stalls, the queue (QueueDepth entries) absorbs requests;
// in_ready_o drops only when it is full.
// reset empties the queue and output register and clears the held byte.
module schema_text_tokenizer #(
  parameter int unsigned QueueDepth = sttok_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] kind_o,
  output logic       token_first_o,
  output logic       token_last_o,
  output logic       last_o
);

  logic              q_full;
  logic              push;
  sttok_pkg::entry_t push_entry;
  logic              head_valid;
  sttok_pkg::entry_t head;
  logic              pop;

  sttok_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .char_byte_i (char_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  sttok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  sttok_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .token_first_o (token_first_o),
    .token_last_o  (token_last_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/testbench.sv
// testbench for schema_text_tokenizer: byte and end-of-input requests go in,
// token bytes come out and are checked against a tokenizer model kept here
// depends on sttok_pkg and the rtl under rtl/core
module testbench;

  localparam int unsigned DirRows    = 25;
  localparam int unsigned RandItems  = 1025;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned CycleLimit = 200000;

  localparam string IdHead = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string IdTail = "_:0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string Digits = "0123456789";
  localparam string HexDig = "0123456789abcdefABCDEF";
  localparam string Syms   = "{}()/*;,<>.|@";

  typedef struct packed {
    logic [7:0]       b;
    sttok_pkg::kind_e kind;
    logic             first;
    logic             tlast;
    logic             lst;
  } tok_t;

  typedef struct packed {
    sttok_pkg::op_e op;
    logic [7:0]     c;
    logic           fixed;
    logic [1:0]     n;
    tok_t           r0;
    tok_t           r1;
  } dir_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = sttok_pkg::OpChar;
  logic [7:0] char_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [2:0] kind_o;
  logic       token_first_o;
  logic       token_last_o;
  logic       last_o;

  schema_text_tokenizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .char_byte_i  (char_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .token_first_o(token_first_o),
    .token_last_o (token_last_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  int cycle_cnt  = 0;
  int n_err      = 0;
  int n_sent     = 0;
  int n_flush    = 0;
  int n_seen     = 0;
  int burst_left = 0;
  bit stall_req  = 1'b0;

  // token model state: the byte held back and the scan mode of its token
  logic             pend_ok;
  logic [7:0]       pend_byte;
  sttok_pkg::kind_e pend_kind;
  logic             pend_first;
  sttok_pkg::mode_e pend_mode;
  tok_t             tok_want_q[$];

  function automatic tok_t tok(logic [7:0] b, sttok_pkg::kind_e k, logic f, logic t,
                               logic l);
    tok_t r;
    r.b = b;
    r.kind = k;
    r.first = f;
    r.tlast = t;
    r.lst = l;
    return r;
  endfunction

  function automatic dir_row_t fix(sttok_pkg::op_e op, logic [7:0] c, logic [1:0] n,
                                   tok_t a, tok_t b);
    dir_row_t r;
    r.op = op;
    r.c = c;
    r.fixed = 1'b1;
    r.n = n;
    r.r0 = a;
    r.r1 = b;
    return r;
  endfunction

  function automatic dir_row_t chr(logic [7:0] c);
    dir_row_t r;
    r = fix(sttok_pkg::OpChar, c, 2'd0, '0, '0);
    r.fixed = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] pick_ch(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hexdig(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c inside {"{", "}", "(", ")", "/", "*", ";", ",", "<", ">", ".", "|", "@"};
  endfunction

  // mode after c when c continues the held token, idle when it ends it
  function automatic sttok_pkg::mode_e grow_mode(sttok_pkg::mode_e m, logic [7:0] c);
    sttok_pkg::mode_e r;
    r = sttok_pkg::ModeIdle;
    case (m)
      sttok_pkg::ModeIdent: begin
        if (is_letter(c) || is_dig(c) || c == "_" || c == ":") r = sttok_pkg::ModeIdent;
      end
      sttok_pkg::ModeSign: begin
        if (c == "0") r = sttok_pkg::ModeZero;
        else if (is_dig(c)) r = sttok_pkg::ModeDec;
      end
      sttok_pkg::ModeZero: begin
        if (c == "x" || c == "X") r = sttok_pkg::ModeHex;
        else if (is_dig(c)) r = sttok_pkg::ModeDec;
      end
      sttok_pkg::ModeDec: begin
        if (is_dig(c)) r = sttok_pkg::ModeDec;
      end
      sttok_pkg::ModeHex: begin
        if (is_hexdig(c)) r = sttok_pkg::ModeHex;
      end
      default: r = sttok_pkg::ModeIdle;
    endcase
    return r;
  endfunction

  function automatic void drop_pending();
    pend_ok = 1'b0;
    pend_byte = 8'h00;
    pend_kind = sttok_pkg::KindSymbol;
    pend_first = 1'b0;
    pend_mode = sttok_pkg::ModeIdle;
  endfunction

  // advance the model by one request; queue its results when keep is set
  function automatic void scan_request(sttok_pkg::op_e op, logic [7:0] c, bit keep);
    sttok_pkg::mode_e nxt;
    if (op == sttok_pkg::OpFlush) begin
      if (pend_ok && keep) tok_want_q.push_back(tok(pend_byte, pend_kind, pend_first, 1'b1, 1'b0));
      if (keep) tok_want_q.push_back(tok(8'h00, sttok_pkg::KindEnd, 1'b1, 1'b1, 1'b1));
      drop_pending();
      return;
    end
    nxt = pend_ok ? grow_mode(pend_mode, c) : sttok_pkg::ModeIdle;
    if (nxt != sttok_pkg::ModeIdle) begin
      if (keep) tok_want_q.push_back(tok(pend_byte, pend_kind, pend_first, 1'b0, 1'b1));
      pend_byte = c;
      pend_first = 1'b0;
      pend_mode = nxt;
      return;
    end
    if (pend_ok && keep) tok_want_q.push_back(tok(pend_byte, pend_kind, pend_first, 1'b1, 1'b1));
    if (is_blank(c)) begin
      drop_pending();
      return;
    end
    pend_ok = 1'b1;
    pend_byte = c;
    pend_first = 1'b1;
    if (is_punct(c)) begin
      pend_kind = sttok_pkg::KindSymbol;
      pend_mode = sttok_pkg::ModeSingle;
    end else if (is_letter(c) || c == "_") begin
      pend_kind = sttok_pkg::KindIdent;
      pend_mode = sttok_pkg::ModeIdent;
    end else if (c == "+" || c == "-") begin
      pend_kind = sttok_pkg::KindNumber;
      pend_mode = sttok_pkg::ModeSign;
    end else if (c == "0") begin
      pend_kind = sttok_pkg::KindNumber;
      pend_mode = sttok_pkg::ModeZero;
    end else if (is_dig(c)) begin
      pend_kind = sttok_pkg::KindNumber;
      pend_mode = sttok_pkg::ModeDec;
    end else begin
      pend_kind = sttok_pkg::KindOther;
      pend_mode = sttok_pkg::ModeSingle;
    end
  endfunction

  task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at result %0d: %s got 0x%02h want 0x%02h", n_seen, what, got, want);
    n_err++;
  endtask

  // sender works in bursts with random gaps in between
  task automatic send_paced(sttok_pkg::op_e op, logic [7:0] c, bit keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    char_byte_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    scan_request(op, c, keep);
    n_sent++;
    if (op == sttok_pkg::OpFlush) n_flush++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, tok_want_q.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin : out_check
    tok_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_seen++;
      if (tok_want_q.size() == 0) begin
        note_mismatch("result with nothing due, byte", out_byte_o, 8'h00);
      end else begin
        want = tok_want_q.pop_front();
        if (out_byte_o !== want.b) note_mismatch("out_byte", out_byte_o, want.b);
        if (kind_o !== want.kind) note_mismatch("kind", kind_o, want.kind);
        if (token_first_o !== want.first) note_mismatch("token_first", token_first_o, want.first);
        if (token_last_o !== want.tlast) note_mismatch("token_last", token_last_o, want.tlast);
        if (last_o !== want.lst) note_mismatch("last", last_o, want.lst);
      end
    end
  end

  // receiver: random stall patterns that change now and then, plus one long hold-off
  initial begin : rx_side
    int mode_left;
    int rx_mode;
    int hold_left;
    mode_left = 0;
    rx_mode = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (mode_left % 3 == 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stim
    dir_row_t   dir_tab [DirRows];
    logic [7:0] frag[$];
    logic [7:0] ws;
    int         pick;
    int         len;
    bit         sgn;
    bit         hold_done;

    drop_pending();
    hold_done = 1'b0;
    dir_tab = '{
      // end of input right after reset gives the end token alone
      fix(sttok_pkg::OpFlush, 8'ha5, 2'd1,
          tok(8'h00, sttok_pkg::KindEnd, 1'b1, 1'b1, 1'b1), '0),
      fix(sttok_pkg::OpChar, 8'h00, 2'd0, '0, '0),
      fix(sttok_pkg::OpChar, 8'hff, 2'd1,
          tok(8'h00, sttok_pkg::KindOther, 1'b1, 1'b1, 1'b1), '0),
      fix(sttok_pkg::OpChar, "{", 2'd1,
          tok(8'hff, sttok_pkg::KindOther, 1'b1, 1'b1, 1'b1), '0),
      fix(sttok_pkg::OpChar, "_", 2'd1,
          tok("{", sttok_pkg::KindSymbol, 1'b1, 1'b1, 1'b1), '0),
      chr("Z"), chr(":"), chr("9"), chr(" "),
      // lone sign, then signed hex with a digit after the prefix
      chr("+"), chr(";"), chr("-"), chr("0"), chr("x"), chr("f"), chr("G"), chr(8'h09),
      // bare hex prefix, then x after a digit that is not a leading zero
      chr("0"), chr("X"), chr("@"), chr("7"), chr("x"), chr(8'h0d), chr("q"),
      fix(sttok_pkg::OpFlush, 8'h00, 2'd2,
          tok("q", sttok_pkg::KindIdent, 1'b1, 1'b1, 1'b0),
          tok(8'h00, sttok_pkg::KindEnd, 1'b1, 1'b1, 1'b1))
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_paced(dir_tab[i].op, dir_tab[i].c, !dir_tab[i].fixed);
      if (dir_tab[i].fixed && dir_tab[i].n > 0) tok_want_q.push_back(dir_tab[i].r0);
      if (dir_tab[i].fixed && dir_tab[i].n > 1) tok_want_q.push_back(dir_tab[i].r1);
    end

    while (n_sent < DirRows + RandItems) begin
      // long output hold-off while requests keep coming
      if (!hold_done && n_sent >= 500) begin
        stall_req = 1'b1;
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      frag.delete();
      if (pick < 4) begin
        send_paced(sttok_pkg::OpFlush, 8'($urandom_range(0, 255)), 1'b1);
      end else begin
        if (pick < 26) begin
          frag.push_back(pick_ch(IdHead));
          repeat ($urandom_range(0, 7)) frag.push_back(pick_ch(IdTail));
        end else if (pick < 40) begin
          sgn = ($urandom_range(0, 2) == 0);
          if (sgn) frag.push_back($urandom_range(0, 1) ? "+" : "-");
          len = $urandom_range(sgn ? 0 : 1, 5);
          repeat (len) frag.push_back(pick_ch(Digits));
        end else if (pick < 50) begin
          if ($urandom_range(0, 2) == 0) frag.push_back($urandom_range(0, 1) ? "+" : "-");
          frag.push_back("0");
          frag.push_back($urandom_range(0, 1) ? "x" : "X");
          repeat ($urandom_range(0, 4)) frag.push_back(pick_ch(HexDig));
        end else if (pick < 70) begin
          frag.push_back(pick_ch(Syms));
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 2)) begin
            ws = ($urandom_range(0, 2) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
            frag.push_back(ws);
          end
        end else begin
          frag.push_back(8'($urandom_range(0, 255)));
        end
        foreach (frag[i]) send_paced(sttok_pkg::OpChar, frag[i], 1'b1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tok_want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d requests, %0d of them end of input, and checked %0d token results",
             n_sent, n_flush, n_seen);
    $display("mixed idents, signed decimal and hex numbers, symbols, blanks and raw bytes");
    if (n_err == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: schema_text_tokenizer.f
rtl/core/sttok_pkg.sv
rtl/core/sttok_front.sv
rtl/core/sttok_queue.sv
rtl/core/sttok_back.sv
rtl/core/schema_text_tokenizer.sv
tb/testbench.sv
